### rtl/hlrc_pkg.sv
// Shared types, constants, character helpers and the microcode table of the response checker.
package hlrc_pkg;

	localparam int MAX_WORDS = 8;
	localparam int MAX_BYTES = 16;

	localparam int WC_W   = 4;
	localparam int KEEP_W = 5;
	localparam int POS_W  = 6;
	localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CFG_W  = 5;
	localparam int IDXR_W = 2;

	// Configuration register indexes
	localparam logic [IDXR_W-1:0] REG_WORD_COUNT    = 2'd0;
	localparam logic [IDXR_W-1:0] REG_KEEP_BYTES    = 2'd1;
	localparam logic [IDXR_W-1:0] REG_REPEAT_FILTER = 2'd2;

	// Frame positions of the end code characters and of the first data character
	localparam logic [POS_W-1:0] POS_EC_HI = 6'd5;
	localparam logic [POS_W-1:0] POS_EC_LO = 6'd6;
	localparam logic [POS_W-1:0] POS_DATA  = 6'd7;

	// Remote end codes
	localparam logic [7:0] EC_NONE   = 8'h00;
	localparam logic [7:0] EC_FCS    = 8'h13;
	localparam logic [7:0] EC_FORMAT = 8'h14;
	localparam logic [7:0] EC_ENTRY  = 8'h15;
	localparam logic [7:0] EC_LENGTH = 8'h18;
	localparam logic [7:0] EC_CPU    = 8'h21;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_FCS        = 3'd1,
		STAT_REMOTE_FCS = 3'd2,
		STAT_FORMAT     = 3'd3,
		STAT_ENTRY      = 3'd4,
		STAT_LENGTH     = 3'd5,
		STAT_CPU        = 3'd6,
		STAT_OTHER      = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		SP_WAIT     = 4'd0,
		SP_PARSE    = 4'd1,
		SP_DISPATCH = 4'd2,
		SP_CHECK    = 4'd3,
		SP_CMP      = 4'd4,
		SP_CMPEND   = 4'd5,
		SP_COPY     = 4'd6,
		SP_EMPTY    = 4'd7,
		SP_EMIT     = 4'd8,
		SP_ERR      = 4'd9
	} step_t;

	typedef enum logic [3:0] {
		C_ALWAYS     = 4'd0,
		C_ACCEPT     = 4'd1,
		C_NO_RESULT  = 4'd2,
		C_ERROR      = 4'd3,
		C_FILTER_OFF = 4'd4,
		C_IDX_DONE   = 4'd5,
		C_EQUAL      = 4'd6,
		C_KEEP_ZERO  = 4'd7,
		C_LAST_OUT   = 4'd8
	} cond_t;

	// Datapath operations enabled by one control word
	typedef struct packed {
		logic accept;
		logic parse;
		logic clr_idx;
		logic cmp;
		logic cmpend;
		logic copy;
		logic load_data;
		logic load_err;
	} ctrl_t;

	// Branch conditions reported by the datapath
	typedef struct packed {
		logic accept;
		logic no_result;
		logic error;
		logic filter_off;
		logic idx_done;
		logic equal;
		logic keep_zero;
		logic last_out;
		logic out_free;
	} conds_t;

	typedef struct packed {
		ctrl_t ops;
		logic  wait_out;
		cond_t cond;
		step_t t_true;
		step_t t_false;
	} uword_t;

	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [7:0] t;
		t = ch - 8'd55;
		if (ch >= 8'd48 && ch <= 8'd57) begin
			return ch[3:0];
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			return t[3:0];
		end else begin
			return 4'd0;
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		c = {4'd0, nib & 4'h0F} + 8'd48;
		if (c > 8'd57) begin
			c = c + 8'd7;
		end
		return c;
	endfunction

	function automatic status_t map_end_code(input logic [7:0] code);
		case (code)
			EC_FCS:    return STAT_REMOTE_FCS;
			EC_FORMAT: return STAT_FORMAT;
			EC_ENTRY:  return STAT_ENTRY;
			EC_LENGTH: return STAT_LENGTH;
			EC_CPU:    return STAT_CPU;
			default:   return STAT_OTHER;
		endcase
	endfunction

	// The control program: one word per step.
	function automatic uword_t ucode(input step_t sp);
		uword_t uw;
		uw = uword_t'('0);
		uw.cond    = C_ALWAYS;
		uw.t_true  = SP_WAIT;
		uw.t_false = SP_WAIT;
		case (sp)
			SP_WAIT: begin
				uw.ops.accept = 1'b1;
				uw.cond       = C_ACCEPT;
				uw.t_true     = SP_PARSE;
				uw.t_false    = SP_WAIT;
			end
			SP_PARSE: begin
				uw.ops.parse = 1'b1;
				uw.cond      = C_NO_RESULT;
				uw.t_true    = SP_WAIT;
				uw.t_false   = SP_DISPATCH;
			end
			SP_DISPATCH: begin
				uw.ops.clr_idx = 1'b1;
				uw.cond        = C_ERROR;
				uw.t_true      = SP_ERR;
				uw.t_false     = SP_CHECK;
			end
			SP_CHECK: begin
				uw.cond    = C_FILTER_OFF;
				uw.t_true  = SP_EMPTY;
				uw.t_false = SP_CMP;
			end
			SP_CMP: begin
				uw.ops.cmp = 1'b1;
				uw.cond    = C_IDX_DONE;
				uw.t_true  = SP_CMPEND;
				uw.t_false = SP_CMP;
			end
			SP_CMPEND: begin
				uw.ops.cmpend  = 1'b1;
				uw.ops.clr_idx = 1'b1;
				uw.cond        = C_EQUAL;
				uw.t_true      = SP_ERR;
				uw.t_false     = SP_COPY;
			end
			SP_COPY: begin
				uw.ops.copy = 1'b1;
				uw.cond     = C_IDX_DONE;
				uw.t_true   = SP_EMPTY;
				uw.t_false  = SP_COPY;
			end
			SP_EMPTY: begin
				uw.ops.clr_idx = 1'b1;
				uw.cond        = C_KEEP_ZERO;
				uw.t_true      = SP_ERR;
				uw.t_false     = SP_EMIT;
			end
			SP_EMIT: begin
				uw.ops.load_data = 1'b1;
				uw.wait_out      = 1'b1;
				uw.cond          = C_LAST_OUT;
				uw.t_true        = SP_WAIT;
				uw.t_false       = SP_EMIT;
			end
			SP_ERR: begin
				uw.ops.load_err = 1'b1;
				uw.wait_out     = 1'b1;
				uw.cond         = C_ALWAYS;
				uw.t_true       = SP_WAIT;
				uw.t_false      = SP_WAIT;
			end
			default: begin
				uw.cond    = C_ALWAYS;
				uw.t_true  = SP_WAIT;
				uw.t_false = SP_WAIT;
			end
		endcase
		return uw;
	endfunction

endpackage

### rtl/hlrc_seq.sv
// Step counter and branch logic that runs the microcode program of the response checker.
module hlrc_seq
	import hlrc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  conds_t conds,
	output ctrl_t  ctrl
);

	step_t  step_q;
	step_t  step_next;
	uword_t uw;
	logic   hold;
	logic   taken;

	always_comb begin
		uw = ucode(step_q);
		// A step that loads the output register waits while the register is full and its transaction is not taken.
		hold = uw.wait_out && !conds.out_free;
		case (uw.cond)
			C_ALWAYS:     taken = 1'b1;
			C_ACCEPT:     taken = conds.accept;
			C_NO_RESULT:  taken = conds.no_result;
			C_ERROR:      taken = conds.error;
			C_FILTER_OFF: taken = conds.filter_off;
			C_IDX_DONE:   taken = conds.idx_done;
			C_EQUAL:      taken = conds.equal;
			C_KEEP_ZERO:  taken = conds.keep_zero;
			C_LAST_OUT:   taken = conds.last_out;
			default:      taken = 1'b1;
		endcase
		if (hold) begin
			step_next = step_q;
		end else if (taken) begin
			step_next = uw.t_true;
		end else begin
			step_next = uw.t_false;
		end
		ctrl = uw.ops;
		if (hold) begin
			ctrl.load_data = 1'b0;
			ctrl.load_err  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= SP_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

### rtl/host_link_response_checker.sv
// Top level of the host-link read-response checker: ports, configuration and datapath.
//
// The checker takes a read-response frame one character per transaction and delivers its
// verdict at the end of the frame: either a single status transaction, or the kept data
// bytes as a run closed by tlast. A small microcoded sequencer drives the datapath. Each
// character goes through an accept step and a parse step. The final parse is followed by a
// dispatch step and, when the frame passes its check, a check step; with the filter on, a
// repeat compare, a compare-end step and, unless the frame is a rejected repeat, a tag
// update; then an empty step, and one result transaction per cycle while the result side
// takes them. A finished result waits in the output register, so the next character is
// accepted while it is still pending.
module host_link_response_checker
	import hlrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
	input  logic              s_axis_tuser,   // [0] frame_start
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,   // [2:0] status, [10:3] data_byte, zero above
	output logic [1:0]        m_axis_tuser,   // [0] repeat_seen, [1] data_valid
	output logic              m_axis_tlast,
	input  logic              cfg_we,
	input  logic [IDXR_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	ctrl_t  ctrl;
	conds_t conds;

	// Configuration
	logic [WC_W-1:0]   word_count_q;
	logic [KEEP_W-1:0] keep_bytes_q;
	logic              repeat_filter_q;

	// Latched character
	logic [7:0] rx_q;
	logic       start_q;

	// Frame state
	logic [POS_W-1:0] position_q;
	logic [7:0]       xor_q;
	logic [3:0]       hn_q;
	logic [7:0]       ec_q;
	logic [7:0]       fcs_first_q;
	logic             done_q;
	logic [7:0]       cur_q [MAX_BYTES];
	logic [7:0]       prev_q [MAX_BYTES];

	// Verdict and loop state
	logic [KEEP_W-1:0] idx_q;
	logic              eq_q;
	logic              err_q;
	status_t           err_status_q;
	logic              rep_q;

	// Output register
	logic       out_valid_q;
	status_t    out_status_q;
	logic       out_rep_q;
	logic       out_dv_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// Parse datapath
	logic [WC_W-1:0]   wc_eff;
	logic [POS_W-1:0]  fcs_pos;
	logic [KEEP_W-1:0] two_wc;
	logic [KEEP_W-1:0] keep;
	logic [POS_W-1:0]  p;
	logic [POS_W-1:0]  d;
	logic [7:0]        xr0;
	logic [7:0]        xr1;
	logic [3:0]        hn0;
	logic [3:0]        hn1;
	logic [7:0]        ec0;
	logic [7:0]        ec1;
	logic [3:0]        nib;
	logic              active;
	logic              ec_err;
	logic              in_data;
	logic              wr_data;
	logic              fcs_hit;
	logic              fcs_end;
	logic              mismatch;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              idx_done;
	logic              out_free;

	hlrc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.conds  (conds),
		.ctrl   (ctrl)
	);

	always_comb begin
		wc_eff  = (word_count_q > WC_W'(MAX_WORDS)) ? WC_W'(MAX_WORDS) : word_count_q;
		fcs_pos = POS_DATA + {wc_eff, 2'b00};
		two_wc  = {wc_eff, 1'b0};
		keep    = (keep_bytes_q > two_wc) ? two_wc : keep_bytes_q;
		if (keep > KEEP_W'(MAX_BYTES)) begin
			keep = KEEP_W'(MAX_BYTES);
		end

		// A start character begins from a cleared frame state.
		p      = start_q ? '0 : position_q;
		xr0    = start_q ? '0 : xor_q;
		hn0    = start_q ? '0 : hn_q;
		ec0    = start_q ? '0 : ec_q;
		active = start_q || !done_q;
		nib    = hex_value(rx_q);

		xr1 = (p < fcs_pos) ? (xr0 ^ rx_q) : xr0;
		ec1 = ec0;
		if (p == POS_EC_HI) begin
			ec1 = {nib, 4'd0};
		end else if (p == POS_EC_LO) begin
			ec1 = ec0 | {4'd0, nib};
		end
		ec_err = (p == POS_EC_LO) && (ec1 != EC_NONE);

		in_data = (p >= POS_DATA) && (p < fcs_pos);
		d       = p - POS_DATA;
		hn1     = (in_data && !d[0]) ? nib : hn0;
		wr_data = in_data && d[0] && ({1'b0, d[POS_W-1:1]} < POS_W'(MAX_BYTES));
		wr_addr = ADDR_W'(d[POS_W-1:1]);

		fcs_hit  = !ec_err && (p == fcs_pos);
		fcs_end  = !ec_err && (p > fcs_pos);
		mismatch = (fcs_first_q != hex_char(xr1[7:4])) || (rx_q != hex_char(xr1[3:0]));

		rd_addr  = idx_q[ADDR_W-1:0];
		idx_done = (idx_q == keep);
		out_free = !out_valid_q || m_axis_tready;

		conds.accept     = s_axis_tvalid;
		conds.no_result  = !(active && (ec_err || fcs_end));
		conds.error      = err_q;
		conds.filter_off = !repeat_filter_q;
		conds.idx_done   = idx_done;
		conds.equal      = eq_q;
		conds.keep_zero  = (keep == '0);
		conds.last_out   = ({1'b0, idx_q} + (KEEP_W + 1)'(1)) == {1'b0, keep};
		conds.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q    <= WC_W'(2);
			keep_bytes_q    <= KEEP_W'(4);
			repeat_filter_q <= 1'b0;
			position_q      <= '0;
			xor_q           <= '0;
			hn_q            <= '0;
			ec_q            <= '0;
			fcs_first_q     <= '0;
			done_q          <= 1'b1;
			idx_q           <= '0;
			eq_q            <= 1'b0;
			err_q           <= 1'b0;
			err_status_q    <= STAT_OK;
			rep_q           <= 1'b0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < MAX_BYTES; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WORD_COUNT:    word_count_q    <= cfg_data[WC_W-1:0];
					REG_KEEP_BYTES:    keep_bytes_q    <= cfg_data[KEEP_W-1:0];
					REG_REPEAT_FILTER: repeat_filter_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (ctrl.parse && active) begin
				xor_q  <= xr1;
				hn_q   <= hn1;
				ec_q   <= ec1;
				done_q <= ec_err || fcs_end;
				if (!ec_err && !fcs_end) begin
					position_q <= p + POS_W'(1);
				end
				if (fcs_hit) begin
					fcs_first_q <= rx_q;
				end
				err_q <= ec_err || mismatch;
				rep_q <= 1'b0;
				if (ec_err) begin
					err_status_q <= map_end_code(ec1);
				end else if (mismatch) begin
					err_status_q <= STAT_FCS;
				end else begin
					err_status_q <= STAT_OK;
				end
			end

			if (ctrl.clr_idx) begin
				idx_q <= '0;
				eq_q  <= 1'b1;
			end
			if (ctrl.cmp && !idx_done) begin
				eq_q  <= eq_q && (prev_q[rd_addr] == cur_q[rd_addr]);
				idx_q <= idx_q + KEEP_W'(1);
			end
			if (ctrl.cmpend && eq_q) begin
				err_status_q <= STAT_OTHER;
				rep_q        <= 1'b1;
			end
			if (ctrl.copy && !idx_done) begin
				prev_q[rd_addr] <= cur_q[rd_addr];
				idx_q           <= idx_q + KEEP_W'(1);
			end

			if (ctrl.load_data) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + KEEP_W'(1);
			end else if (ctrl.load_err) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (ctrl.accept && s_axis_tvalid) begin
			rx_q    <= s_axis_tdata;
			start_q <= s_axis_tuser;
		end
		if (ctrl.parse && active && wr_data) begin
			cur_q[wr_addr] <= {hn0, nib};
		end
		if (ctrl.load_data) begin
			out_status_q <= STAT_OK;
			out_rep_q    <= 1'b0;
			out_dv_q     <= 1'b1;
			out_byte_q   <= cur_q[rd_addr];
			out_last_q   <= conds.last_out;
		end else if (ctrl.load_err) begin
			out_status_q <= err_status_q;
			out_rep_q    <= rep_q;
			out_dv_q     <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign s_axis_tready = ctrl.accept;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_byte_q, out_status_q};
	assign m_axis_tuser  = {out_dv_q, out_rep_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### tb/sv/host_link_response_checker_tb.sv
// Self-checking testbench for the host-link read-response checker.
`timescale 1ns / 1ps

module host_link_response_checker_tb
	import hlrc_pkg::*;
();

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] REMOTE_CODES [5] = '{EC_FCS, EC_FORMAT, EC_ENTRY, EC_LENGTH, EC_CPU};

	typedef struct packed {
		status_t    status;
		logic       repeat_seen;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       last;
	} resp_t;

	typedef enum logic {ROW_STRAY, ROW_FRAME} row_kind_t;
	typedef enum logic [2:0] {DS_HEX, DS_ANY, DS_ALL_F, DS_ZERO, DS_AGAIN} fill_t;

	// One directed row: configuration, frame shape and, where obvious, the verdict.
	typedef struct packed {
		row_kind_t  kind;
		logic [3:0] wc;
		logic [4:0] keep;
		logic       filt;
		logic [7:0] ec_hi;
		logic [7:0] ec_lo;
		fill_t      fill;
		logic       fcs_good;
		logic [5:0] cut;
		logic       typed;
		resp_t      want;
	} case_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [15:0]       m_axis_tdata;
	logic [1:0]        m_axis_tuser;
	logic              m_axis_tlast;
	logic              cfg_we;
	logic [IDXR_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	// Predictor state
	logic [3:0]  w_reg;
	logic [4:0]  keep_reg;
	logic        filt_reg;
	logic [5:0]  pos;
	logic [7:0]  xsum;
	logic [3:0]  hi_nib;
	logic [7:0]  ecode;
	logic [7:0]  fcs_hi_char;
	logic        in_frame;
	logic [7:0]  frame_bytes [MAX_BYTES];
	logic [7:0]  tag_bytes [MAX_BYTES];

	resp_t       fresh [$];
	resp_t       pending_verdicts [$];
	logic [7:0]  prior_chars [32];
	case_t       plan [17];
	logic        typed_row;
	resp_t       typed_want;
	bit          feed_burst;
	bit          sink_burst;
	int          frame_chars;
	int          err_count;

	host_link_response_checker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		if (ch >= CH_0 && ch <= CH_9) begin
			return 4'(ch - CH_0);
		end else if (ch >= CH_A && ch <= CH_F) begin
			return 4'(ch - CH_A + 8'd10);
		end
		return 4'd0;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return (nib < 4'd10) ? CH_0 + 8'(nib) : CH_A + 8'(nib) - 8'd10;
	endfunction

	function automatic status_t code_status(input logic [7:0] code);
		case (code)
			EC_FCS:    return STAT_REMOTE_FCS;
			EC_FORMAT: return STAT_FORMAT;
			EC_ENTRY:  return STAT_ENTRY;
			EC_LENGTH: return STAT_LENGTH;
			EC_CPU:    return STAT_CPU;
			default:   return STAT_OTHER;
		endcase
	endfunction

	function automatic resp_t flag_only(input status_t st, input logic rep);
		return '{st, rep, 1'b0, 8'h00, 1'b1};
	endfunction

	function automatic int pick_gap(input bit burst);
		if (burst) begin
			return 0;
		end
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
	endfunction

	// Advances the predictor by one accepted character and leaves its verdicts in fresh.
	function automatic void parse_char(input logic [7:0] rx, input logic st);
		int         wc;
		int         fpos;
		int         keep;
		int         d;
		bit         same;
		logic [3:0] nib;
		nib = hex_nibble(rx);
		fresh.delete();
		if (st) begin
			pos      = '0;
			xsum     = '0;
			hi_nib   = '0;
			ecode    = '0;
			in_frame = 1'b1;
		end else if (!in_frame) begin
			return;
		end
		wc   = (w_reg > MAX_WORDS) ? MAX_WORDS : int'(w_reg);
		fpos = 7 + 4 * wc;
		if (pos < fpos) begin
			xsum = xsum ^ rx;
		end
		if (pos == POS_EC_HI) begin
			ecode = {nib, 4'h0};
		end else if (pos == POS_EC_LO) begin
			ecode = {ecode[7:4], nib};
			if (ecode != EC_NONE) begin
				fresh.push_back(flag_only(code_status(ecode), 1'b0));
				in_frame = 1'b0;
				return;
			end
		end else if (pos >= POS_DATA && pos < fpos) begin
			d = int'(pos) - 7;
			if (d % 2 == 0) begin
				hi_nib = nib;
			end else if (d / 2 < MAX_BYTES) begin
				frame_bytes[d / 2] = {hi_nib, nib};
			end
		end
		if (pos == fpos) begin
			fcs_hi_char = rx;
		end else if (pos > fpos) begin
			in_frame = 1'b0;
			if (fcs_hi_char != hex_digit(xsum[7:4]) || rx != hex_digit(xsum[3:0])) begin
				fresh.push_back(flag_only(STAT_FCS, 1'b0));
				return;
			end
			keep = keep_reg;
			if (keep > 2 * wc) keep = 2 * wc;
			if (keep > MAX_BYTES) keep = MAX_BYTES;
			if (filt_reg) begin
				same = 1'b1;
				for (int i = 0; i < keep; i++) begin
					if (tag_bytes[i] != frame_bytes[i]) same = 1'b0;
				end
				if (same) begin
					fresh.push_back(flag_only(STAT_OTHER, 1'b1));
					return;
				end
				for (int i = 0; i < keep; i++) begin
					tag_bytes[i] = frame_bytes[i];
				end
			end
			if (keep == 0) begin
				fresh.push_back(flag_only(STAT_OK, 1'b0));
				return;
			end
			for (int i = 0; i < keep; i++) begin
				fresh.push_back(resp_t'{STAT_OK, 1'b0, 1'b1, frame_bytes[i], i == keep - 1});
			end
			return;
		end
		pos = pos + 6'd1;
	endfunction

	function automatic logic [7:0] data_char(input fill_t fill, input int idx);
		case (fill)
			DS_HEX:   return hex_digit(4'($urandom_range(0, 15)));
			DS_ANY:   return 8'($urandom_range(0, 255));
			DS_ALL_F: return CH_F;
			DS_ZERO:  return CH_0;
			default:  return prior_chars[idx];
		endcase
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic st);
		int gap;
		gap = pick_gap(feed_burst);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= st;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		parse_char(ch, st);
		if (fresh.size() != 0) begin
			if (typed_row) begin
				pending_verdicts.push_back(typed_want);
			end else begin
				foreach (fresh[i]) pending_verdicts.push_back(fresh[i]);
			end
		end
		@(negedge clk);
	endtask

	// Sends one frame; cut, when nonzero, stops it after that many characters.
	task automatic send_frame(input logic [7:0] ec_hi, input logic [7:0] ec_lo, input fill_t fill,
			input logic fcs_good, input int cut);
		int         fpos;
		logic [7:0] ch;
		logic [7:0] fsum;
		logic [7:0] c_hi;
		logic [7:0] c_lo;
		fpos = 7 + 4 * ((w_reg > MAX_WORDS) ? MAX_WORDS : int'(w_reg));
		fsum = '0;
		for (int n = 0; n < fpos; n++) begin
			if (cut != 0 && n == cut) return;
			if (n == 5) begin
				ch = ec_hi;
			end else if (n == 6) begin
				ch = ec_lo;
			end else if (n < 5) begin
				ch = 8'($urandom_range(0, 255));
			end else begin
				ch = data_char(fill, n - 7);
				prior_chars[n - 7] = ch;
			end
			fsum = fsum ^ ch;
			send_char(ch, n == 0);
			frame_chars++;
			// A nonzero end code closes the frame straight away.
			if (n == 6 && {hex_nibble(ec_hi), hex_nibble(ec_lo)} != EC_NONE) return;
		end
		c_hi = hex_digit(fsum[7:4]);
		c_lo = hex_digit(fsum[3:0]);
		if (!fcs_good) begin
			if ($urandom_range(0, 1) == 1) c_hi = c_hi ^ (8'd1 << $urandom_range(0, 7));
			else c_lo = c_lo ^ (8'd1 << $urandom_range(0, 7));
		end
		send_char(c_hi, 1'b0);
		send_char(c_lo, 1'b0);
		frame_chars += 2;
	endtask

	// Holds the feed off until every verdict is in and the sequencer has settled.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDXR_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_WORD_COUNT:    w_reg    = val[3:0];
			REG_KEEP_BYTES:    keep_reg = val;
			REG_REPEAT_FILTER: filt_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		resp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				err_count++;
				$display("%0t: unexpected transaction, expected none, actual status %0d data 0x%0h",
					$time, m_axis_tdata[2:0], m_axis_tdata[10:3]);
			end else begin
				want = pending_verdicts.pop_front();
				check_field("status", want.status, m_axis_tdata[2:0]);
				check_field("repeat_seen", want.repeat_seen, m_axis_tuser[0]);
				check_field("data_valid", want.data_valid, m_axis_tuser[1]);
				check_field("data_byte", want.data_byte, m_axis_tdata[10:3]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	// Result side: a fresh stall is drawn for every transaction.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			stall = pick_gap(sink_burst);
			repeat (stall) begin
				m_axis_tready <= 1'b0;
				@(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int         r;
		int         frames;
		int         cut;
		int         fpos;
		logic [7:0] ec_hi;
		logic [7:0] ec_lo;
		logic [7:0] code;
		fill_t      fill;
		logic       good;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_WORD_COUNT;
		cfg_data      = '0;
		w_reg         = 4'd2;
		keep_reg      = 5'd4;
		filt_reg      = 1'b0;
		pos           = '0;
		xsum          = '0;
		hi_nib        = '0;
		ecode         = '0;
		fcs_hi_char   = '0;
		in_frame      = 1'b0;
		typed_row     = 1'b0;
		typed_want    = '0;
		feed_burst    = 1'b0;
		sink_burst    = 1'b0;
		frame_chars   = 0;
		err_count     = 0;
		foreach (tag_bytes[i]) tag_bytes[i] = '0;
		foreach (frame_bytes[i]) frame_bytes[i] = '0;
		foreach (prior_chars[i]) prior_chars[i] = CH_0;

		// Lower-case and other non-hex characters read as zero, so "a0" is a clean end code.
		plan = '{
			'{ROW_STRAY, 2, 4, 0, 8'hFF, 0, DS_HEX, 1, 0, 1, '0},
			'{ROW_STRAY, 2, 4, 0, 8'h00, 0, DS_HEX, 1, 0, 1, '0},
			'{ROW_FRAME, 2, 4, 0, "1", "3", DS_HEX, 1, 0, 1, flag_only(STAT_REMOTE_FCS, 0)},
			'{ROW_FRAME, 2, 4, 0, "1", "4", DS_HEX, 1, 0, 1, flag_only(STAT_FORMAT, 0)},
			'{ROW_FRAME, 2, 4, 0, "1", "5", DS_HEX, 1, 0, 1, flag_only(STAT_ENTRY, 0)},
			'{ROW_FRAME, 2, 4, 0, "1", "8", DS_HEX, 1, 0, 1, flag_only(STAT_LENGTH, 0)},
			'{ROW_FRAME, 2, 4, 0, "2", "1", DS_HEX, 1, 0, 1, flag_only(STAT_CPU, 0)},
			'{ROW_FRAME, 2, 4, 0, "F", "F", DS_HEX, 1, 0, 1, flag_only(STAT_OTHER, 0)},
			'{ROW_FRAME, 2, 4, 0, "a", "0", DS_ANY, 1, 0, 0, '0},
			'{ROW_FRAME, 0, 4, 0, "0", "0", DS_HEX, 1, 0, 1, flag_only(STAT_OK, 0)},
			'{ROW_FRAME, 0, 4, 0, "0", "0", DS_HEX, 0, 0, 1, flag_only(STAT_FCS, 0)},
			'{ROW_FRAME, 15, 31, 0, "0", "0", DS_HEX, 1, 6, 0, '0},
			'{ROW_FRAME, 15, 31, 0, "0", "0", DS_ALL_F, 1, 0, 0, '0},
			'{ROW_FRAME, 2, 0, 1, "0", "0", DS_HEX, 1, 0, 1, flag_only(STAT_OTHER, 1)},
			'{ROW_FRAME, 2, 4, 1, "0", "0", DS_ZERO, 1, 0, 1, flag_only(STAT_OTHER, 1)},
			'{ROW_FRAME, 2, 4, 1, "0", "0", DS_HEX, 1, 0, 0, '0},
			'{ROW_FRAME, 2, 4, 1, "0", "0", DS_AGAIN, 1, 0, 1, flag_only(STAT_OTHER, 1)}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].wc != w_reg || plan[i].keep != keep_reg || plan[i].filt != filt_reg) begin
				settle();
				if (plan[i].wc != w_reg) write_reg(REG_WORD_COUNT, 5'(plan[i].wc));
				if (plan[i].keep != keep_reg) write_reg(REG_KEEP_BYTES, plan[i].keep);
				if (plan[i].filt != filt_reg) write_reg(REG_REPEAT_FILTER, 5'(plan[i].filt));
			end
			typed_row  = plan[i].typed;
			typed_want = plan[i].want;
			if (plan[i].kind == ROW_STRAY) begin
				send_char(plan[i].ec_hi, 1'b0);
			end else begin
				send_frame(plan[i].ec_hi, plan[i].ec_lo, plan[i].fill, plan[i].fcs_good,
					int'(plan[i].cut));
			end
		end
		typed_row = 1'b0;

		while (frame_chars < 210) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 6) write_reg(REG_WORD_COUNT, 5'($urandom_range(0, 3)));
			else if (r < 8) write_reg(REG_WORD_COUNT, 5'(MAX_WORDS));
			else write_reg(REG_WORD_COUNT, 5'($urandom_range(0, 15)));
			write_reg(REG_KEEP_BYTES, 5'($urandom_range(0, 31)));
			write_reg(REG_REPEAT_FILTER, 5'($urandom_range(0, 1)));
			feed_burst = ($urandom_range(0, 3) == 0);
			sink_burst = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(2, 5);
			for (int f = 0; f < frames; f++) begin
				if (!in_frame && $urandom_range(0, 9) == 0) begin
					send_char(8'($urandom_range(0, 255)), 1'b0);
				end
				r = $urandom_range(0, 19);
				if (r < 3) begin
					code  = REMOTE_CODES[$urandom_range(0, 4)];
					ec_hi = hex_digit(code[7:4]);
					ec_lo = hex_digit(code[3:0]);
				end else if (r == 3) begin
					ec_hi = 8'($urandom_range(0, 255));
					ec_lo = 8'($urandom_range(0, 255));
				end else begin
					ec_hi = CH_0;
					ec_lo = CH_0;
				end
				r = $urandom_range(0, 19);
				if (r < 11) fill = DS_HEX;
				else if (r < 14) fill = DS_ANY;
				else if (r < 17) fill = DS_AGAIN;
				else if (r == 17) fill = DS_ZERO;
				else fill = DS_ALL_F;
				good = ($urandom_range(0, 6) != 0);
				// The last frame of a batch is never cut, so no frame is left open.
				fpos = 7 + 4 * ((w_reg > MAX_WORDS) ? MAX_WORDS : int'(w_reg));
				cut = 0;
				if (f < frames - 1 && $urandom_range(0, 11) == 0) begin
					cut = $urandom_range(1, fpos - 1);
				end
				send_frame(ec_hi, ec_lo, fill, good, cut);
			end
		end

		settle();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### host_link_response_checker.f
rtl/hlrc_pkg.sv
rtl/hlrc_seq.sv
rtl/host_link_response_checker.sv
tb/sv/host_link_response_checker_tb.sv
